// ===== design/vt4_pkg.sv =====
package vt4_pkg;

   localparam int CoordBits  = 32;
   localparam int FracBits   = 16;
   localparam int QueueDepth = 4;

   localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
   localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_VEC4  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic [3:0]                  entry_index;
      logic signed [CoordBits-1:0] entry_value;
      logic signed [CoordBits-1:0] in_x;
      logic signed [CoordBits-1:0] in_y;
      logic signed [CoordBits-1:0] in_z;
      logic signed [CoordBits-1:0] in_w;
      logic                        batch_last;
   } req_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] out_x;
      logic signed [CoordBits-1:0] out_y;
      logic signed [CoordBits-1:0] out_z;
      logic signed [CoordBits-1:0] out_w;
      logic                        divide_fault;
      logic                        batch_end;
   } rsp_type;

   // one vertex job between front and back
   typedef struct packed {
      logic                        point;
      logic signed [CoordBits-1:0] vx;
      logic signed [CoordBits-1:0] vy;
      logic signed [CoordBits-1:0] vz;
      logic signed [CoordBits-1:0] vw;
      logic                        last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/vertex_transform_4x4_top.sv =====
// Homogeneous 4x4 matrix transform, signed fixed point with FRAC_BITS fraction bits.
// req channel: req_valid/req_stall with one req item. op OP_LOAD writes one
// column-major matrix entry and gives no result; OP_POINT transforms (x,y,z,1)
// and divides x,y,z by w; OP_VEC4 transforms (x,y,z,w). Code 3 is dropped.
// rsp channel: rsp_valid/rsp_stall with one rsp item per transform, in order.
// Throughput: one vertex per cycle while not stalled. A load waits until the job
// queue is empty so that queued vertices see the matrix that was current when
// they arrived. Each vertex passes the multiply stage, the row sum stage, the
// bit-per-stage divider pipeline and the output register.
// A rsp_stall while rsp_valid is high freezes the whole back pipeline; the front
// keeps taking vertices until the job queue fills.
// Reset (synchronous, active high) loads the identity matrix and empties the
// queue and the pipeline.
module vertex_transform_4x4_top #(
   parameter int FRAC_BITS = vt4_pkg::FracBits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vt4_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vt4_pkg::rsp_type  rsp
);
   import vt4_pkg::*;

   logic                       push;
   logic                       pop;
   job_type                    push_data;
   job_type                    head;
   queue_status_type           qstat;
   logic [16*CoordBits-1:0]    matrix;

   vt4_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data),
      .matrix    (matrix)
   );

   vt4_queue #(.DEPTH(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   vt4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .matrix    (matrix),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== design/vt4_queue.sv =====
module vt4_queue #(
   parameter int DEPTH = vt4_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vt4_pkg::job_type           push_data,
   input  logic                       pop,
   output vt4_pkg::job_type           head,
   output vt4_pkg::queue_status_type  status
);
   import vt4_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/vt4_front.sv =====
module vt4_front #(
   parameter int FRAC_BITS = vt4_pkg::FracBits
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  vt4_pkg::req_type                      req,
   input  vt4_pkg::queue_status_type             qstat,
   output logic                                  push,
   output vt4_pkg::job_type                      push_data,
   output logic [16*vt4_pkg::CoordBits-1:0]      matrix
);
   import vt4_pkg::*;

   localparam int CB = CoordBits;

   logic [CB-1:0] mat_ff [16];
   logic          accept;
   logic          is_load;

   // a load waits until every queued job has read the matrix
   assign is_load   = (req.op == OP_LOAD);
   assign req_stall = qstat.full || (is_load && !qstat.empty);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req.op inside {OP_POINT, OP_VEC4});

   always_comb begin
      push_data.point = (req.op == OP_POINT);
      push_data.vx    = req.in_x;
      push_data.vy    = req.in_y;
      push_data.vz    = req.in_z;
      push_data.vw    = (req.op == OP_POINT) ? (CB'(1) << FRAC_BITS) : req.in_w;
      push_data.last  = req.batch_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? (CB'(1) << FRAC_BITS) : '0;
         end
      end else if (accept && is_load) begin
         mat_ff[req.entry_index] <= req.entry_value;
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         matrix[i*CB +: CB] = mat_ff[i];
      end
   end

endmodule

// ===== design/vt4_back.sv =====
module vt4_back #(
   parameter int FRAC_BITS = vt4_pkg::FracBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vt4_pkg::job_type                  head,
   input  vt4_pkg::queue_status_type         qstat,
   output logic                              pop,
   input  logic [16*vt4_pkg::CoordBits-1:0]  matrix,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output vt4_pkg::rsp_type                  rsp
);
   import vt4_pkg::*;

   localparam int CB = CoordBits;
   localparam int QB = CB + FRAC_BITS;

   function automatic logic signed [CB-1:0] sat_prod(input logic signed [2*CB-1:0] p);
      logic signed [2*CB-1:0] s;
      s = p >>> FRAC_BITS;
      if (s[2*CB-1:CB-1] == '0 || s[2*CB-1:CB-1] == '1) begin
         return s[CB-1:0];
      end
      return s[2*CB-1] ? CoordMin : CoordMax;
   endfunction

   function automatic logic signed [CB-1:0] sat_sum(input logic signed [CB+1:0] s);
      if (s[CB+1:CB-1] == '0 || s[CB+1:CB-1] == '1) begin
         return s[CB-1:0];
      end
      return s[CB+1] ? CoordMin : CoordMax;
   endfunction

   logic adv;

   // product stage
   logic                     s1_vld_ff;
   logic                     s1_point_ff;
   logic                     s1_last_ff;
   logic signed [2*CB-1:0]   prod_ff [4][4];

   // row sum stage
   logic                     s2_vld_ff;
   logic                     s2_point_ff;
   logic                     s2_last_ff;
   logic signed [CB-1:0]     row_ff [4];

   // divider stages; every stage after stage 0 adds one quotient bit
   logic                     d_vld_ff   [0:QB], d_vld_in   [0:QB];
   logic                     d_point_ff [0:QB], d_point_in [0:QB];
   logic                     d_last_ff  [0:QB], d_last_in  [0:QB];
   logic                     d_fault_ff [0:QB], d_fault_in [0:QB];
   logic signed [CB-1:0]     d_w_ff     [0:QB], d_w_in     [0:QB];
   logic [CB-1:0]            d_den_ff   [0:QB], d_den_in   [0:QB];
   logic signed [CB-1:0]     d_raw_ff   [0:QB][3], d_raw_in [0:QB][3];
   logic                     d_neg_ff   [0:QB][3], d_neg_in [0:QB][3];
   logic [CB:0]              d_rem_ff   [0:QB][3], d_rem_in [0:QB][3];
   logic [QB-1:0]            d_num_ff   [0:QB][3], d_num_in [0:QB][3];
   logic [QB-1:0]            d_quo_ff   [0:QB][3], d_quo_in [0:QB][3];

   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= !qstat.empty;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_point_ff <= head.point;
         s1_last_ff  <= head.last;
         for (int r = 0; r < 4; r++) begin
            prod_ff[r][0] <= head.vx * $signed(matrix[(r)*CB +: CB]);
            prod_ff[r][1] <= head.vy * $signed(matrix[(r+4)*CB +: CB]);
            prod_ff[r][2] <= head.vz * $signed(matrix[(r+8)*CB +: CB]);
            prod_ff[r][3] <= head.vw * $signed(matrix[(r+12)*CB +: CB]);
         end
         s2_point_ff <= s1_point_ff;
         s2_last_ff  <= s1_last_ff;
         for (int r = 0; r < 4; r++) begin
            row_ff[r] <= sat_sum((CB+2)'(sat_prod(prod_ff[r][0]))
                               + (CB+2)'(sat_prod(prod_ff[r][1]))
                               + (CB+2)'(sat_prod(prod_ff[r][2]))
                               + (CB+2)'(sat_prod(prod_ff[r][3])));
         end
      end
   end

   always_comb begin
      logic [CB+1:0] trial;
      logic          ge;
      d_vld_in[0]   = s2_vld_ff;
      d_point_in[0] = s2_point_ff;
      d_last_in[0]  = s2_last_ff;
      d_fault_in[0] = s2_point_ff && (row_ff[3] == '0);
      d_w_in[0]     = row_ff[3];
      d_den_in[0]   = row_ff[3][CB-1] ? CB'(-row_ff[3]) : CB'(row_ff[3]);
      for (int l = 0; l < 3; l++) begin
         d_raw_in[0][l] = row_ff[l];
         d_neg_in[0][l] = row_ff[l][CB-1] != row_ff[3][CB-1];
         d_rem_in[0][l] = '0;
         d_num_in[0][l] = QB'(row_ff[l][CB-1] ? CB'(-row_ff[l]) : CB'(row_ff[l]))
                          << FRAC_BITS;
         d_quo_in[0][l] = '0;
      end
      for (int k = 0; k < QB; k++) begin
         d_vld_in[k+1]   = d_vld_ff[k];
         d_point_in[k+1] = d_point_ff[k];
         d_last_in[k+1]  = d_last_ff[k];
         d_fault_in[k+1] = d_fault_ff[k];
         d_w_in[k+1]     = d_w_ff[k];
         d_den_in[k+1]   = d_den_ff[k];
         for (int l = 0; l < 3; l++) begin
            trial = {d_rem_ff[k][l], d_num_ff[k][l][QB-1]};
            ge    = trial >= (CB+2)'(d_den_ff[k]);
            d_raw_in[k+1][l] = d_raw_ff[k][l];
            d_neg_in[k+1][l] = d_neg_ff[k][l];
            d_rem_in[k+1][l] = ge ? (CB+1)'(trial - (CB+2)'(d_den_ff[k]))
                                  : trial[CB:0];
            d_num_in[k+1][l] = d_num_ff[k][l] << 1;
            d_quo_in[k+1][l] = {d_quo_ff[k][l][QB-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            d_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k <= QB; k++) begin
            d_vld_ff[k] <= d_vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= QB; k++) begin
            d_point_ff[k] <= d_point_in[k];
            d_last_ff[k]  <= d_last_in[k];
            d_fault_ff[k] <= d_fault_in[k];
            d_w_ff[k]     <= d_w_in[k];
            d_den_ff[k]   <= d_den_in[k];
            for (int l = 0; l < 3; l++) begin
               d_raw_ff[k][l] <= d_raw_in[k][l];
               d_neg_ff[k][l] <= d_neg_in[k][l];
               d_rem_ff[k][l] <= d_rem_in[k][l];
               d_num_ff[k][l] <= d_num_in[k][l];
               d_quo_ff[k][l] <= d_quo_in[k][l];
            end
         end
      end
   end

   always_comb begin
      logic [CB-1:0]        limit;
      logic [CB-1:0]        mag;
      logic signed [CB-1:0] res [3];
      for (int l = 0; l < 3; l++) begin
         limit = CB'(CoordMax) + CB'(d_neg_ff[QB][l]);
         mag   = (d_quo_ff[QB][l] > QB'(limit)) ? limit : d_quo_ff[QB][l][CB-1:0];
         if (!d_point_ff[QB]) begin
            res[l] = d_raw_ff[QB][l];
         end else if (d_fault_ff[QB]) begin
            res[l] = d_raw_ff[QB][l][CB-1] ? CoordMin : CoordMax;
         end else begin
            res[l] = d_neg_ff[QB][l] ? -mag : mag;
         end
      end
      rsp_in.out_x        = res[0];
      rsp_in.out_y        = res[1];
      rsp_in.out_z        = res[2];
      rsp_in.out_w        = d_w_ff[QB];
      rsp_in.divide_fault = d_fault_ff[QB];
      rsp_in.batch_end    = d_last_ff[QB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import vt4_pkg::*;

   localparam int Latency = 4 + 32 + FracBits;
   localparam int IdleLimit = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   vertex_transform_4x4_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   req_type pending[$];
   rsp_type expected_vertices[$];
   logic signed [CoordBits-1:0] matrix[16];
   int errors = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit send_quiet = 0;
   bit recv_quiet = 0;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [CoordBits-1:0] clamp(longint v);
      if (v > longint'(CoordMax)) return CoordMax;
      if (v < longint'(CoordMin)) return CoordMin;
      return v[CoordBits-1:0];
   endfunction

   function automatic longint row_dot(int r, longint v[4]);
      longint acc;
      acc = 0;
      for (int c = 0; c < 4; c++)
         acc += longint'(clamp((v[c] * longint'(matrix[r + 4*c])) >>> FracBits));
      return longint'(clamp(acc));
   endfunction

   function automatic logic signed [CoordBits-1:0] fx_div(longint n, longint d);
      return clamp((n <<< FracBits) / d);
   endfunction

   task automatic apply_vertex(req_type it);
      longint v[4], r[4];
      rsp_type o;
      if (it.op == OP_LOAD) begin
         matrix[it.entry_index] = it.entry_value;
         return;
      end
      if (it.op != OP_POINT && it.op != OP_VEC4) return;
      v[0] = it.in_x;
      v[1] = it.in_y;
      v[2] = it.in_z;
      v[3] = (it.op == OP_POINT) ? (longint'(1) <<< FracBits) : longint'(it.in_w);
      for (int j = 0; j < 4; j++) r[j] = row_dot(j, v);
      o = '0;
      o.batch_end = it.batch_last;
      o.out_w = CoordBits'(r[3]);
      if (it.op == OP_POINT) begin
         if (r[3] == 0) begin
            o.divide_fault = 1'b1;
            o.out_x = r[0] < 0 ? CoordMin : CoordMax;
            o.out_y = r[1] < 0 ? CoordMin : CoordMax;
            o.out_z = r[2] < 0 ? CoordMin : CoordMax;
         end else begin
            o.out_x = fx_div(r[0], r[3]);
            o.out_y = fx_div(r[1], r[3]);
            o.out_z = fx_div(r[2], r[3]);
         end
      end else begin
         o.out_x = CoordBits'(r[0]);
         o.out_y = CoordBits'(r[1]);
         o.out_z = CoordBits'(r[2]);
      end
      expected_vertices.push_back(o);
   endtask

   task automatic report(string what, logic [CoordBits-1:0] got, logic [CoordBits-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic signed [CoordBits-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return CoordMax;
         1: return CoordMin;
         2: return $urandom;
         3: return $urandom;
         default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      endcase
   endfunction

   function automatic req_type make_item(op_type op);
      req_type it;
      it.op = op;
      it.entry_index = 4'($urandom_range(0, 15));
      it.entry_value = rand_coord();
      it.in_x = rand_coord();
      it.in_y = rand_coord();
      it.in_z = rand_coord();
      it.in_w = rand_coord();
      it.batch_last = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic queue_load(int idx, logic signed [CoordBits-1:0] val);
      req_type it;
      it = make_item(OP_LOAD);
      it.entry_index = 4'(idx);
      it.entry_value = val;
      pending.push_back(it);
   endtask

   task automatic queue_vertex(op_type op, logic signed [CoordBits-1:0] x,
                               logic signed [CoordBits-1:0] y,
                               logic signed [CoordBits-1:0] z,
                               logic signed [CoordBits-1:0] w, logic last);
      req_type it;
      it = make_item(op);
      it.in_x = x; it.in_y = y; it.in_z = z; it.in_w = w;
      it.batch_last = last;
      pending.push_back(it);
   endtask

   task automatic load_identity();
      for (int i = 0; i < 16; i++)
         queue_load(i, (i % 5 == 0) ? (32'sd1 <<< FracBits) : 32'sd0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) apply_vertex(req);
         if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            req <= pending.pop_front();
            req_valid <= 1'b1;
            send_gap = pick_gap(send_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_vertices.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               errors++;
            end else begin
               want = expected_vertices.pop_front();
               if (rsp.out_x !== want.out_x) report("out_x", rsp.out_x, want.out_x);
               if (rsp.out_y !== want.out_y) report("out_y", rsp.out_y, want.out_y);
               if (rsp.out_z !== want.out_z) report("out_z", rsp.out_z, want.out_z);
               if (rsp.out_w !== want.out_w) report("out_w", rsp.out_w, want.out_w);
               if (rsp.divide_fault !== want.divide_fault)
                  report("divide_fault", CoordBits'(rsp.divide_fault),
                         CoordBits'(want.divide_fault));
               if (rsp.batch_end !== want.batch_end)
                  report("batch_end", CoordBits'(rsp.batch_end), CoordBits'(want.batch_end));
            end
         end
         if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap = pick_gap(recv_quiet);
            rsp_stall <= (recv_gap > 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("vertex_transform_4x4_top verification failed");
         $finish;
      end
   end

   initial begin
      req = '0;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      for (int i = 0; i < 16; i++)
         matrix[i] = (i % 5 == 0) ? (32'sd1 <<< FracBits) : 32'sd0;

      // identity, extremes through both transforms, and one item with code 3
      queue_vertex(OP_POINT, 32'sd65536, -32'sd131072, 32'sd3, 0, 1'b0);
      queue_vertex(OP_VEC4, CoordMax, CoordMin, 0, CoordMax, 1'b1);
      queue_vertex(OP_VEC4, CoordMin, CoordMin, CoordMax, CoordMin, 1'b0);
      begin
         req_type it;
         it = make_item(OP_VEC4);
         it.op = op_type'(2'd3);
         pending.push_back(it);
      end
      // scale to saturate, then zero w row
      queue_load(0, CoordMax);
      queue_load(5, CoordMin);
      queue_load(12, CoordMax);
      queue_vertex(OP_VEC4, CoordMax, CoordMax, -32'sd5, CoordMin, 1'b1);
      queue_vertex(OP_POINT, CoordMin, CoordMax, 32'sd7, 0, 1'b0);
      queue_load(15, 32'sd0);
      queue_vertex(OP_POINT, -32'sd65536, 32'sd65536, 32'sd0, 0, 1'b1);
      queue_vertex(OP_POINT, 32'sd1, -32'sd1, -32'sd9, 0, 1'b0);
      queue_load(3, 32'sd1);
      queue_vertex(OP_POINT, 32'sd1, 32'sd2, CoordMin, 0, 1'b0);
      load_identity();

      for (int n = 0; n < 1500; n++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 15) begin
            pending.push_back(make_item(OP_LOAD));
         end else if (r < 17) begin
            for (int k = 3; k < 16; k += 4) queue_load(k, 32'sd0);
         end else if (r < 18) begin
            req_type it;
            it = make_item(OP_POINT);
            it.op = op_type'(2'd3);
            pending.push_back(it);
         end else if (r < 19) begin
            load_identity();
         end else begin
            pending.push_back(make_item(r < 60 ? OP_POINT : OP_VEC4));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (pending.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_vertices.size() > 0) @(posedge clock);
      repeat (Latency + 20) @(posedge clock);

      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("vertex_transform_4x4_top verification clean");
      end else begin
         $display("vertex_transform_4x4_top verification failed");
      end
      $finish;
   end

endmodule

// ===== vertex_transform_4x4_top.f =====
design/vt4_pkg.sv
design/vt4_queue.sv
design/vt4_front.sv
design/vt4_back.sv
design/vertex_transform_4x4_top.sv
tb/testbench.sv
